@@ design/aes_pkg.sv @@
`timescale 1ns / 1ps

package aes_pkg;

  localparam int unsigned NumRounds  = 14;
  localparam int unsigned NumWords   = 60;
  localparam int unsigned MaxKeyWords = 8;
  localparam int unsigned CntW = $clog2(NumWords);

  typedef enum logic [1:0] {
    KeySize128 = 2'd0,
    KeySize192 = 2'd1,
    KeySize256 = 2'd2
  } key_size_e;

  typedef enum logic [2:0] {
    RegKeySize  = 3'd0,
    RegKeyWord0 = 3'd1,
    RegKeyWord1 = 3'd2,
    RegKeyWord2 = 3'd3,
    RegKeyWord3 = 3'd4
  } reg_idx_e;

  localparam logic [7:0] InvAffC = 8'h05;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
    logic [15:0] d;
    d = {v, v} << n;
    return d[15:8];
  endfunction

  function automatic logic [7:0] affine_undo(input logic [7:0] c);
    return rotl8(c, 1) ^ rotl8(c, 3) ^ rotl8(c, 6) ^ InvAffC;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] c);
    return SBOX[c];
  endfunction

  // field inverse recovered from the forward table through the inverse affine map
  function automatic logic [7:0] inv_sub_byte(input logic [7:0] c);
    return affine_undo(SBOX[affine_undo(c)]);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k]  = c[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    r[31:24] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
    r[23:16] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
    r[15:8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
    r[7:0]   = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    return r;
  endfunction

  // byte i of the state sits at bits 127-8i, row i%4, column i/4
  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int unsigned src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*src) -: 8];
      end
    end
    return t;
  endfunction

endpackage

@@ design/aes_block_cipher_top.sv @@
`timescale 1ns / 1ps

// AES encrypt/decrypt pipeline: one 128-bit block per clock while no output beat
// waits and no key expansion runs. An accepted input beat reaches its output
// through an input key-add register plus one register per round cell, 14 cells;
// 128/192-bit keys pass through the unused cells. The whole chain holds while
// the output beat waits. After reset and after every key size or key word write
// the key schedule is expanded one 32-bit word per cycle; s_axis_tready is low meanwhile.
module aes_block_cipher_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_hi [63:0], block_lo [127:64]
  input  logic         s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_hi [63:0], result_lo [127:64]
);

  localparam int unsigned NR = aes_pkg::NumRounds;

  logic         busy;
  logic [1:0]   ksz;
  logic [127:0] rkey [NR+1];
  logic         en;
  logic         v [NR+1];
  logic         f [NR+1];
  logic [127:0] s [NR+1];
  logic [127:0] in_state, key_last, key_dec [NR+1];
  logic         v0_q, f0_q;
  logic [127:0] s0_q;

  aes_kexp u_kexp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .busy_o(busy), .key_size_o(ksz), .rkey_o(rkey)
  );

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign in_state      = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  // decrypt round key for cell j is round nr-j
  for (genvar j = 0; j <= NR; j++) begin : g_kd
    always_comb begin
      unique case (ksz)
        aes_pkg::KeySize128: key_dec[j] = (j <= 10) ? rkey[(j <= 10) ? 10 - j : 0] : '0;
        aes_pkg::KeySize192: key_dec[j] = (j <= 12) ? rkey[(j <= 12) ? 12 - j : 0] : '0;
        default:             key_dec[j] = rkey[NR - j];
      endcase
    end
  end
  assign key_last = key_dec[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q <= s_axis_tuser;
      s0_q <= in_state ^ (s_axis_tuser ? key_last : rkey[0]);
    end
  end

  assign v[0] = v0_q;
  assign f[0] = f0_q;
  assign s[0] = s0_q;

  for (genvar j = 1; j <= NR; j++) begin : g_cell
    logic active, last;
    always_comb begin
      unique case (ksz)
        aes_pkg::KeySize128: begin active = (j <= 10); last = (j == 10); end
        aes_pkg::KeySize192: begin active = (j <= 12); last = (j == 12); end
        default:             begin active = 1'b1;      last = (j == NR); end
      endcase
    end
    aes_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .active_i(active), .last_i(last),
      .key_enc_i(rkey[j]), .key_dec_i(key_dec[j]),
      .valid_i(v[j-1]), .func_i(f[j-1]), .state_i(s[j-1]),
      .valid_o(v[j]), .func_o(f[j]), .state_o(s[j])
    );
  end

  assign m_axis_tvalid = v[NR];
  assign m_axis_tdata  = {s[NR][63:0], s[NR][127:64]};

endmodule

@@ design/aes_kexp.sv @@
`timescale 1ns / 1ps

module aes_kexp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  output logic         busy_o,
  output logic [1:0]   key_size_o,
  output logic [127:0] rkey_o [aes_pkg::NumRounds+1]
);

  logic [1:0]  ksz_q;
  logic [63:0] kw_q [4];
  logic        busy_q;
  logic [aes_pkg::CntW-1:0] cnt_q;
  logic [2:0]  pos_q;
  logic [7:0]  rc_q;
  logic [31:0] win_q [aes_pkg::MaxKeyWords];
  logic [31:0] rk_q [aes_pkg::NumWords];

  logic [2:0]  nk_m1;
  logic [31:0] w_new, t, kword;
  logic [63:0] ksel;
  logic        key_phase, restart;

  always_comb begin
    unique case (ksz_q)
      aes_pkg::KeySize128: nk_m1 = 3'd3;
      aes_pkg::KeySize192: nk_m1 = 3'd5;
      default:             nk_m1 = 3'd7;
    endcase
  end

  assign key_phase = ({{(aes_pkg::CntW-3){1'b0}}, nk_m1} >= cnt_q);
  assign ksel  = kw_q[cnt_q[2:1]];
  assign kword = cnt_q[0] ? ksel[31:0] : ksel[63:32];

  always_comb begin
    t = win_q[0];
    if (pos_q == 3'd0) begin
      t = aes_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk_m1 == 3'd7 && pos_q == 3'd4) begin
      t = aes_pkg::sub_word(win_q[0]);
    end
    w_new = key_phase ? kword : (win_q[nk_m1] ^ t);
  end

  assign restart = cfg_we_i && (cfg_idx_i <= aes_pkg::RegKeyWord3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksz_q  <= aes_pkg::KeySize128;
      for (int k = 0; k < 4; k++) kw_q[k] <= '0;
      busy_q <= 1'b1;
      cnt_q  <= '0;
      pos_q  <= '0;
      rc_q   <= 8'h01;
    end else if (restart) begin
      if (cfg_idx_i == aes_pkg::RegKeySize) begin
        ksz_q <= (cfg_data_i[1:0] == 2'd3) ? aes_pkg::KeySize256 : cfg_data_i[1:0];
      end else begin
        kw_q[cfg_idx_i[1:0] - 2'd1] <= cfg_data_i;
      end
      busy_q <= 1'b1;
      cnt_q  <= '0;
      pos_q  <= '0;
      rc_q   <= 8'h01;
    end else if (busy_q) begin
      busy_q <= (cnt_q != aes_pkg::CntW'(aes_pkg::NumWords - 1));
      cnt_q  <= cnt_q + 1'b1;
      pos_q  <= (pos_q == nk_m1) ? 3'd0 : pos_q + 3'd1;
      if (!key_phase && pos_q == 3'd0) rc_q <= aes_pkg::xtime(rc_q);
    end
  end

  // word store and sliding window of the last eight words
  always_ff @(posedge clk_i) begin
    if (busy_q && !restart) begin
      rk_q[cnt_q] <= w_new;
      win_q[0] <= w_new;
      for (int k = 1; k < aes_pkg::MaxKeyWords; k++) win_q[k] <= win_q[k-1];
    end
  end

  for (genvar r = 0; r <= aes_pkg::NumRounds; r++) begin : g_rk
    assign rkey_o[r] = {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
  end

  assign busy_o     = busy_q;
  assign key_size_o = ksz_q;

endmodule

@@ design/aes_cell.sv @@
`timescale 1ns / 1ps

module aes_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         active_i,
  input  logic         last_i,
  input  logic [127:0] key_enc_i,
  input  logic [127:0] key_dec_i,
  input  logic         valid_i,
  input  logic         func_i,
  input  logic [127:0] state_i,
  output logic         valid_o,
  output logic         func_o,
  output logic [127:0] state_o
);

  logic         valid_q, func_q;
  logic [127:0] state_q, state_d, sr, sb, sk, mx;

  always_comb begin
    if (!func_i) begin
      for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = aes_pkg::sub_byte(state_i[127-8*i -: 8]);
      sr = aes_pkg::row_rotate(sb, 1'b0);
      for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = aes_pkg::mix_col(sr[127-32*c -: 32]);
      sk = (last_i ? sr : mx) ^ key_enc_i;
    end else begin
      sr = aes_pkg::row_rotate(state_i, 1'b1);
      for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = aes_pkg::inv_sub_byte(sr[127-8*i -: 8]);
      mx = sb ^ key_dec_i;
      for (int c = 0; c < 4; c++) begin
        sk[127-32*c -: 32] = last_i ? mx[127-32*c -: 32] : aes_pkg::inv_mix_col(mx[127-32*c -: 32]);
      end
    end
    // rounds past the last one for this key size pass the state on
    state_d = active_i ? sk : state_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q  <= func_i;
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign func_o  = func_q;
  assign state_o = state_q;

endmodule
